// ===== rtl/rhsv_pkg.sv =====
// rhsv_pkg: pixel transaction types, widths and scale constants for the
// rgb to hsv pixel converter. depends on nothing.
`default_nettype none
package rhsv_pkg;

  localparam int unsigned PIX_W     = 8;
  // sector term s stays below 6*255
  localparam int unsigned S_W       = 11;
  localparam int unsigned HUE_DEN_W = 12;
  localparam int unsigned HUE_NUM_W = HUE_DEN_W + PIX_W;
  localparam int unsigned SAT_DEN_W = 9;
  localparam int unsigned SAT_NUM_W = SAT_DEN_W + PIX_W;

  localparam int unsigned HUE_SCALE = 510;
  localparam int unsigned HUE_BIAS  = 6;
  localparam int unsigned HUE_DIV   = 12;
  localparam int unsigned SAT_SCALE = 510;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } in_pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } out_pixel_t;

  // operands handed from the front end to the divider pipeline
  typedef struct packed {
    logic                 valid;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [HUE_DEN_W-1:0] hue_den;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [SAT_DEN_W-1:0] sat_den;
    logic [PIX_W-1:0]     brightness;
  } div_job_t;

endpackage
`default_nettype wire

// ===== rtl/rhsv_front.sv =====
// rhsv_front: two register stages, max/min and sector term, then the
// divider operands. depends on rhsv_pkg.
`default_nettype none
module rhsv_front
  import rhsv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_pixel_t in_pixel,
  output div_job_t       job
);

  logic             a_valid_r;
  logic [PIX_W-1:0] a_mx_r, a_mx_nxt;
  logic [PIX_W-1:0] a_d_r, a_d_nxt;
  logic [S_W-1:0]   a_s_r, a_s_nxt;

  div_job_t         b_job_r, b_job_nxt;

  logic [PIX_W-1:0] mn;
  logic [S_W-1:0]   r_w, g_w, b_w, d_w;

  always_comb begin
    a_mx_nxt = in_pixel.red;
    mn       = in_pixel.red;
    if (in_pixel.green > a_mx_nxt) a_mx_nxt = in_pixel.green;
    if (in_pixel.blue  > a_mx_nxt) a_mx_nxt = in_pixel.blue;
    if (in_pixel.green < mn)       mn       = in_pixel.green;
    if (in_pixel.blue  < mn)       mn       = in_pixel.blue;
    a_d_nxt = a_mx_nxt - mn;

    r_w = S_W'(in_pixel.red);
    g_w = S_W'(in_pixel.green);
    b_w = S_W'(in_pixel.blue);
    d_w = S_W'(a_d_nxt);

    // ties on the maximum go to red first, then green
    if (a_mx_nxt == in_pixel.red) begin
      if (in_pixel.green >= in_pixel.blue) a_s_nxt = g_w - b_w;
      else                                 a_s_nxt = S_W'(6) * d_w - (b_w - g_w);
    end else if (a_mx_nxt == in_pixel.green) begin
      a_s_nxt = S_W'(2) * d_w + b_w - r_w;
    end else begin
      a_s_nxt = S_W'(4) * d_w + r_w - g_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else        a_valid_r <= in_valid;
    a_mx_r <= a_mx_nxt;
    a_d_r  <= a_d_nxt;
    a_s_r  <= a_s_nxt;
  end

  always_comb begin
    b_job_nxt.valid      = a_valid_r;
    b_job_nxt.brightness = a_mx_r;
    if (a_d_r == '0) begin
      // gray: zero over one gives zero hue and saturation
      b_job_nxt.hue_num = '0;
      b_job_nxt.hue_den = HUE_DEN_W'(1);
      b_job_nxt.sat_num = '0;
      b_job_nxt.sat_den = SAT_DEN_W'(1);
    end else begin
      b_job_nxt.hue_num = HUE_NUM_W'(a_s_r) * HUE_NUM_W'(HUE_SCALE)
                        + HUE_NUM_W'(a_d_r) * HUE_NUM_W'(HUE_BIAS);
      b_job_nxt.hue_den = HUE_DEN_W'(a_d_r) * HUE_DEN_W'(HUE_DIV);
      b_job_nxt.sat_num = SAT_NUM_W'(a_d_r) * SAT_NUM_W'(SAT_SCALE)
                        + SAT_NUM_W'(a_mx_r);
      b_job_nxt.sat_den = {a_mx_r, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_job_r.valid <= 1'b0;
    else        b_job_r.valid <= b_job_nxt.valid;
    b_job_r.hue_num    <= b_job_nxt.hue_num;
    b_job_r.hue_den    <= b_job_nxt.hue_den;
    b_job_r.sat_num    <= b_job_nxt.sat_num;
    b_job_r.sat_den    <= b_job_nxt.sat_den;
    b_job_r.brightness <= b_job_nxt.brightness;
  end

  assign job = b_job_r;

endmodule
`default_nettype wire

// ===== rtl/rhsv_div_step.sv =====
// rhsv_div_step: one registered stage of a restoring divider, producing
// STEP_BITS quotient bits from FIRST_BIT down. depends on nothing.
`default_nettype none
module rhsv_div_step #(
  parameter int unsigned DEN_W     = 12,
  parameter int unsigned QUO_W     = 8,
  parameter int unsigned STEP_BITS = 2,
  parameter int unsigned FIRST_BIT = 7
) (
  input  wire logic                   clk,
  input  wire logic [DEN_W+QUO_W-1:0] rem_in,
  input  wire logic [DEN_W-1:0]       den_in,
  input  wire logic [QUO_W-1:0]       quo_in,
  output logic      [DEN_W+QUO_W-1:0] rem_out,
  output logic      [DEN_W-1:0]       den_out,
  output logic      [QUO_W-1:0]       quo_out
);

  localparam int unsigned REM_W = DEN_W + QUO_W;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r, quo_nxt;

  always_comb begin
    logic [REM_W-1:0] trial;
    rem_nxt = rem_in;
    quo_nxt = quo_in;
    for (int j = 0; j < STEP_BITS; j++) begin
      trial = REM_W'(den_in) << (FIRST_BIT - j);
      if (rem_nxt >= trial) begin
        rem_nxt = rem_nxt - trial;
        quo_nxt = quo_nxt | (QUO_W'(1) << (FIRST_BIT - j));
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_in;
    quo_r <= quo_nxt;
  end

  assign rem_out = rem_r;
  assign den_out = den_r;
  assign quo_out = quo_r;

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_pixel.sv =====
// rgb_to_hsv_pixel: top level, front end followed by two parallel divider
// pipelines. depends on rhsv_pkg, rhsv_front and rhsv_div_step.
//
// usage: drive in_pixel and raise start; a transaction is taken at every
// rising edge with start high and busy low. busy is always low, so one
// pixel can be taken in every cycle with no gaps.
// each result appears on out_data for exactly one cycle with out_valid
// high, after its pixel has passed both front stages and every divider
// stage. results leave in the order the pixels came.
// throughput is one pixel per cycle; each pixel passes through the two front
// stages (max/min, then operands) and the divider stages, each of which
// resolves STEP_BITS quotient bits of hue and saturation side by side.
// the receiver cannot stall, so nothing is held back at the output.
// a synchronous reset (rst_n low) clears every valid bit in the pipeline;
// pixels in flight are dropped and no result comes out until new pixels
// are taken.
`default_nettype none
module rgb_to_hsv_pixel
  import rhsv_pkg::*;
#(
  parameter int unsigned STEP_BITS = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_pixel_t in_pixel,
  output logic           out_valid,
  output out_pixel_t     out_data
);

  localparam int unsigned NUM_STAGES = PIX_W / STEP_BITS;
  localparam int unsigned HUE_REM_W  = HUE_DEN_W + PIX_W;
  localparam int unsigned SAT_REM_W  = SAT_DEN_W + PIX_W;

  div_job_t job;

  logic [HUE_REM_W-1:0] hue_rem [NUM_STAGES+1];
  logic [HUE_DEN_W-1:0] hue_den [NUM_STAGES+1];
  logic [PIX_W-1:0]     hue_quo [NUM_STAGES+1];
  logic [SAT_REM_W-1:0] sat_rem [NUM_STAGES+1];
  logic [SAT_DEN_W-1:0] sat_den [NUM_STAGES+1];
  logic [PIX_W-1:0]     sat_quo [NUM_STAGES+1];

  logic                 valid_r  [NUM_STAGES];
  logic [PIX_W-1:0]     bright_r [NUM_STAGES];

  assign busy = 1'b0;

  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_pixel (in_pixel),
    .job      (job)
  );

  assign hue_rem[0] = job.hue_num;
  assign hue_den[0] = job.hue_den;
  assign hue_quo[0] = '0;
  assign sat_rem[0] = job.sat_num;
  assign sat_den[0] = job.sat_den;
  assign sat_quo[0] = '0;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_div
    rhsv_div_step #(
      .DEN_W     (HUE_DEN_W),
      .QUO_W     (PIX_W),
      .STEP_BITS (STEP_BITS),
      .FIRST_BIT (PIX_W - 1 - k * STEP_BITS)
    ) u_hue (
      .clk     (clk),
      .rem_in  (hue_rem[k]),
      .den_in  (hue_den[k]),
      .quo_in  (hue_quo[k]),
      .rem_out (hue_rem[k+1]),
      .den_out (hue_den[k+1]),
      .quo_out (hue_quo[k+1])
    );

    rhsv_div_step #(
      .DEN_W     (SAT_DEN_W),
      .QUO_W     (PIX_W),
      .STEP_BITS (STEP_BITS),
      .FIRST_BIT (PIX_W - 1 - k * STEP_BITS)
    ) u_sat (
      .clk     (clk),
      .rem_in  (sat_rem[k]),
      .den_in  (sat_den[k]),
      .quo_in  (sat_quo[k]),
      .rem_out (sat_rem[k+1]),
      .den_out (sat_den[k+1]),
      .quo_out (sat_quo[k+1])
    );

    // valid and brightness ride alongside the divider stages
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) valid_r[k] <= 1'b0;
        else        valid_r[k] <= job.valid;
        bright_r[k] <= job.brightness;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) valid_r[k] <= 1'b0;
        else        valid_r[k] <= valid_r[k-1];
        bright_r[k] <= bright_r[k-1];
      end
    end
  end

  assign out_valid           = valid_r[NUM_STAGES-1];
  assign out_data.hue        = hue_quo[NUM_STAGES];
  assign out_data.saturation = sat_quo[NUM_STAGES];
  assign out_data.brightness = bright_r[NUM_STAGES-1];

endmodule
`default_nettype wire
